// ----- design/awb_pkg.sv -----
`default_nettype none

package awb_pkg;

    localparam int FIELD_W = 16;
    localparam int BASE_W  = 10;
    localparam int DIV2_W  = BASE_W + 8;

    localparam logic [FIELD_W-1:0] TYPICAL_RESET = 16'd1024;
    localparam logic [BASE_W-1:0]  UNITY_SCALE   = 10'd1000;
    localparam logic [7:0]         GAIN_ONE      = 8'h80;
    localparam logic [7:0]         GAIN_MAX      = 8'hFF;

    localparam logic [0:0] REG_TARGET_RG = 1'd0;
    localparam logic [0:0] REG_TARGET_BG = 1'd1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO      = 2'd1;
    localparam logic [1:0] STATUS_BASE_ZERO = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] measured_rg;
        logic [FIELD_W-1:0] measured_bg;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] red_gain;
        logic [7:0] green_gain;
        logic [7:0] blue_gain;
        logic       red_write;
        logic       green_write;
        logic       blue_write;
    } result_t;

    // one queued job: masked operands plus the zero-operand classification
    typedef struct packed {
        logic               zero;
        logic [FIELD_W-1:0] measured_rg;
        logic [FIELD_W-1:0] measured_bg;
        logic [FIELD_W-1:0] target_rg;
        logic [FIELD_W-1:0] target_bg;
    } work_t;

endpackage

`default_nettype wire

// ----- design/awb_golden_gain_calc.sv -----
// The back end works on one beat at a time: the bit-serial ratio divider
//   (RATIO_WIDTH+10 steps), the base pick and the 8-step gain divider, then
//   the result; a beat with a zero ratio or target goes straight to the result.
// A two-entry queue takes new beats while a calculation runs or a result waits.
// Reset (rst_n, async, active low) empties queue and result, targets go to 1024.
`default_nettype none

module awb_golden_gain_calc
    import awb_pkg::*;
#(
    parameter int RATIO_WIDTH = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire item_t              item,
    output logic                    empty,
    input  wire logic               pop,
    output result_t                 result
);

    logic  q_push;
    logic  q_full;
    work_t q_wdata;
    logic  job_valid;
    logic  job_pop;
    work_t job;
    logic  out_valid;

    assign full  = q_full;
    assign empty = !out_valid;

    awb_front #(
        .RATIO_WIDTH(RATIO_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    awb_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data(q_wdata),
        .full   (q_full),
        .rd_en  (job_pop),
        .valid  (job_valid),
        .rd_data(job)
    );

    awb_back #(
        .RATIO_WIDTH(RATIO_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop),
        .out_valid(out_valid),
        .result   (result),
        .pop      (pop)
    );

`ifndef NO_ASSERTIONS
    // failed checks leave every gain and write flag at zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_OK) |->
            (result.red_gain == '0 && result.green_gain == '0 && result.blue_gain == '0 &&
             !result.red_write && !result.green_write && !result.blue_write))
        else $error("nonzero gain on failed result");

    // write flag tracks gain above unity, saturated or not
    a_write_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STATUS_OK) |->
            (result.red_write == (result.red_gain > GAIN_ONE) &&
             result.green_write == (result.green_gain > GAIN_ONE) &&
             result.blue_write == (result.blue_gain > GAIN_ONE)))
        else $error("write flag disagrees with gain");

    // base never exceeds 1000, so green is at least unity
    a_green_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STATUS_OK) |-> (result.green_gain >= GAIN_ONE))
        else $error("green gain below unity");

    // the channel that set the base comes out at exactly unity
    a_unity_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STATUS_OK) |->
            (result.red_gain == GAIN_ONE || result.green_gain == GAIN_ONE ||
             result.blue_gain == GAIN_ONE))
        else $error("no channel at unity gain");
`endif

endmodule

`default_nettype wire

// ----- design/awb_front.sv -----
`default_nettype none

module awb_front
    import awb_pkg::*;
#(
    parameter int RATIO_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_data,
    input  wire logic               push,
    input  wire item_t              item,
    input  wire logic               q_full,
    output logic                    q_push,
    output work_t                   q_data
);

    localparam logic [FIELD_W-1:0] RATIO_MASK =
        FIELD_W'((32'd1 << RATIO_WIDTH) - 32'd1);

    logic [FIELD_W-1:0] target_rg_reg;
    logic [FIELD_W-1:0] target_bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rg_reg <= TYPICAL_RESET;
            target_bg_reg <= TYPICAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_RG: target_rg_reg <= cfg_data;
                REG_TARGET_BG: target_bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        q_push             = push && !q_full;
        q_data.measured_rg = item.measured_rg & RATIO_MASK;
        q_data.measured_bg = item.measured_bg & RATIO_MASK;
        q_data.target_rg   = target_rg_reg & RATIO_MASK;
        q_data.target_bg   = target_bg_reg & RATIO_MASK;
        q_data.zero        = (q_data.measured_rg == '0) || (q_data.measured_bg == '0) ||
                             (q_data.target_rg == '0) || (q_data.target_bg == '0);
    end

endmodule

`default_nettype wire

// ----- design/awb_fifo.sv -----
`default_nettype none

module awb_fifo
    import awb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire work_t wr_data,
    output logic       full,
    input  wire logic  rd_en,
    output logic       valid,
    output work_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_wr;
    logic do_rd;

    assign full    = (count_reg == FULL_COUNT);
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/awb_back.sv -----
`default_nettype none

module awb_back
    import awb_pkg::*;
#(
    parameter int RATIO_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire work_t job,
    output logic       job_pop,
    output logic       out_valid,
    output result_t    result,
    input  wire logic  pop
);

    localparam int RW    = RATIO_WIDTH;
    localparam int QW    = RATIO_WIDTH + BASE_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] DIV1_LAST = CNT_W'(QW - 1);
    localparam logic [CNT_W-1:0] DIV2_LAST = CNT_W'(7);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_BASE = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV2 = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       status_reg, status_next;

    // stage 1: target*1000 / measured, one quotient bit per cycle per ratio
    logic [RW-1:0] mr_reg, mr_next, mb_reg, mb_next;
    logic [RW-1:0] rem_r_reg, rem_r_next, rem_b_reg, rem_b_next;
    logic [QW-1:0] nq_r_reg, nq_r_next, nq_b_reg, nq_b_next;

    logic [BASE_W-1:0] base_reg, base_next;

    // stage 2: 128*v / base for red, green, blue lanes, 8 quotient bits
    logic [DIV2_W-1:0] dsh_reg, dsh_next;
    logic [DIV2_W-1:0] rem2_reg [3];
    logic [DIV2_W-1:0] rem2_next [3];
    logic [7:0]        q_reg [3];
    logic [7:0]        q_next [3];
    logic              sat_reg [3];
    logic              sat_next [3];

    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic [QW-1:0] lane_v [3];
    logic [7:0]    lane_gain [3];
    logic          lane_write [3];
    logic [QW-1:0] two_base;
    logic [QW-1:0] rr_min;
    logic          below_unity;

    function automatic logic [RW+QW-1:0] div_step(input logic [RW-1:0] rem,
                                                  input logic [QW-1:0] nq,
                                                  input logic [RW-1:0] d);
        logic [RW:0] trial;
        logic        ge;
        logic [RW-1:0] rem_o;
        trial = {rem, nq[QW-1]};
        ge    = (trial >= {1'b0, d});
        rem_o = ge ? RW'(trial - {1'b0, d}) : trial[RW-1:0];
        return {rem_o, nq[QW-2:0], ge};
    endfunction

    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        lane_v[0] = nq_r_reg;
        lane_v[1] = QW'(UNITY_SCALE);
        lane_v[2] = nq_b_reg;
        two_base  = QW'({base_reg, 1'b0});
        rr_min    = (nq_r_reg < nq_b_reg) ? nq_r_reg : nq_b_reg;
        below_unity = (nq_r_reg < QW'(UNITY_SCALE)) || (nq_b_reg < QW'(UNITY_SCALE));
        for (int i = 0; i < 3; i++)
        begin
            lane_gain[i]  = sat_reg[i] ? GAIN_MAX : q_reg[i];
            lane_write[i] = sat_reg[i] || (q_reg[i] > GAIN_ONE);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        mr_next        = mr_reg;
        mb_next        = mb_reg;
        rem_r_next     = rem_r_reg;
        rem_b_next     = rem_b_reg;
        nq_r_next      = nq_r_reg;
        nq_b_next      = nq_b_reg;
        base_next      = base_reg;
        dsh_next       = dsh_reg;
        rem2_next      = rem2_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !pop;
        result_next    = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.zero)
                    begin
                        status_next = STATUS_ZERO;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        mr_next     = job.measured_rg[RW-1:0];
                        mb_next     = job.measured_bg[RW-1:0];
                        rem_r_next  = '0;
                        rem_b_next  = '0;
                        nq_r_next   = QW'(job.target_rg[RW-1:0]) * QW'(UNITY_SCALE);
                        nq_b_next   = QW'(job.target_bg[RW-1:0]) * QW'(UNITY_SCALE);
                        cnt_next    = DIV1_LAST;
                        state_next  = S_DIV1;
                    end
                end
            end
            S_DIV1:
            begin
                {rem_r_next, nq_r_next} = div_step(rem_r_reg, nq_r_reg, mr_reg);
                {rem_b_next, nq_b_next} = div_step(rem_b_reg, nq_b_reg, mb_reg);
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                // min is below 1000 whenever it is chosen, so it fits the base width
                base_next  = below_unity ? rr_min[BASE_W-1:0] : UNITY_SCALE;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (base_reg == '0)
                begin
                    status_next = STATUS_BASE_ZERO;
                    state_next  = S_DONE;
                end
                else
                begin
                    // v >= 2*base saturates; otherwise v < 2000 and 128*v fits
                    for (int i = 0; i < 3; i++)
                    begin
                        sat_next[i]  = (lane_v[i] >= two_base);
                        rem2_next[i] = sat_next[i] ? '0 : {lane_v[i][BASE_W:0], 7'b0};
                        q_next[i]    = '0;
                    end
                    dsh_next   = {1'b0, base_reg, 7'b0};
                    cnt_next   = DIV2_LAST;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem2_reg[i] >= dsh_reg)
                    begin
                        rem2_next[i] = rem2_reg[i] - dsh_reg;
                        q_next[i]    = {q_reg[i][6:0], 1'b1};
                    end
                    else
                    begin
                        q_next[i] = {q_reg[i][6:0], 1'b0};
                    end
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next     = 1'b1;
                    result_next.status = status_reg;
                    if (status_reg == STATUS_OK)
                    begin
                        result_next.red_gain    = lane_gain[0];
                        result_next.green_gain  = lane_gain[1];
                        result_next.blue_gain   = lane_gain[2];
                        result_next.red_write   = lane_write[0];
                        result_next.green_write = lane_write[1];
                        result_next.blue_write  = lane_write[2];
                    end
                    else
                    begin
                        result_next.red_gain    = '0;
                        result_next.green_gain  = '0;
                        result_next.blue_gain   = '0;
                        result_next.red_write   = 1'b0;
                        result_next.green_write = 1'b0;
                        result_next.blue_write  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        mr_reg     <= mr_next;
        mb_reg     <= mb_next;
        rem_r_reg  <= rem_r_next;
        rem_b_reg  <= rem_b_next;
        nq_r_reg   <= nq_r_next;
        nq_b_reg   <= nq_b_next;
        base_reg   <= base_next;
        dsh_reg    <= dsh_next;
        rem2_reg   <= rem2_next;
        q_reg      <= q_next;
        sat_reg    <= sat_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire
